// ----- hdl/pcm_to_stereo16_nearest_resampler_core_defines.svh -----
// assertion helpers for the resampler core
`ifndef PCM_TO_STEREO16_NEAREST_RESAMPLER_CORE_DEFINES_SVH
`define PCM_TO_STEREO16_NEAREST_RESAMPLER_CORE_DEFINES_SVH

// plain property, checked on every rising clock edge outside reset
`define PCMRS_CHECK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pcmrs check failed");

// implication form
`define PCMRS_CHECK_IMPL(label, ante, cons) \
  `PCMRS_CHECK(label, (ante) |-> (cons))

`endif

// ----- hdl/pcmrs_pkg.sv -----
`timescale 1ns / 1ps
package pcmrs_pkg;

  localparam int OutputRateDefault = 44100;

  // longest run of output words per input word
  localparam int MaxRun = 6;
  localparam int CntW   = $clog2(MaxRun);

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // configuration port
  localparam int PaddrW = 4;
  localparam logic [1:0] RegStereo  = 2'd0;
  localparam logic [1:0] RegSixteen = 2'd1;
  localparam logic [1:0] RegRate    = 2'd2;
  localparam logic [1:0] RegStatus  = 2'd3;

  localparam logic        StereoReset  = 1'b1;
  localparam logic        SixteenReset = 1'b1;
  localparam logic [15:0] RateReset    = 16'd44100;

  typedef struct packed {
    logic        stereo;
    logic        sixteen;
    logic [15:0] rate;
  } cfg_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } pair_t;

  typedef struct packed {
    logic            running;
    logic            rem_fits;
    logic [CntW-1:0] count;
    logic [1:0]      skip;
  } status_t;

  typedef enum logic {
    StIdle,
    StRun
  } back_state_e;

endpackage

// ----- hdl/pcmrs_in_if.sv -----
`timescale 1ns / 1ps
interface pcmrs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_sample;
  logic [15:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface

// ----- hdl/pcmrs_out_if.sv -----
`timescale 1ns / 1ps
interface pcmrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               last_of_run;

  modport source (output valid, output left_sample, output right_sample,
                  output last_of_run, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input last_of_run, output ready);
endinterface

// ----- hdl/pcmrs_front.sv -----
`timescale 1ns / 1ps
module pcmrs_front (
  input  pcmrs_pkg::cfg_t  cfg_i,
  input  logic             in_valid_i,
  input  logic [15:0]      first_sample_i,
  input  logic [15:0]      second_sample_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output pcmrs_pkg::pair_t push_data_o
);

  // 8-bit unsigned s -> (s - 128) * 256, 16-bit passes as is
  function automatic logic [15:0] widen(input logic [15:0] raw, input logic sixteen);
    logic [15:0] res;
    if (sixteen) begin
      res = raw;
    end else begin
      res = {raw[7:0] ^ 8'h80, 8'h00};
    end
    return res;
  endfunction

  logic [15:0] left_w;

  assign left_w           = widen(first_sample_i, cfg_i.sixteen);
  assign push_data_o.left = left_w;
  // mono copies the first channel
  assign push_data_o.right = cfg_i.stereo ? widen(second_sample_i, cfg_i.sixteen) : left_w;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

// ----- hdl/pcmrs_queue.sv -----
`timescale 1ns / 1ps
module pcmrs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcmrs_pkg::pair_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pcmrs_pkg::pair_t pop_data_o
);

  localparam int Depth = pcmrs_pkg::QueueDepth;

  pcmrs_pkg::pair_t                  mem_q [Depth];
  logic [pcmrs_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pcmrs_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pcmrs_pkg::QCntW-1:0]       cnt_q, cnt_d;

  function automatic logic [pcmrs_pkg::QPtrW-1:0] bump(input logic [pcmrs_pkg::QPtrW-1:0] p);
    logic [pcmrs_pkg::QPtrW-1:0] r;
    if (p == pcmrs_pkg::QPtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o     = (cnt_q == pcmrs_pkg::QCntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? bump(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + pcmrs_pkg::QCntW'(push_i) - pcmrs_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/pcmrs_back.sv -----
`timescale 1ns / 1ps
module pcmrs_back #(
  parameter int OutputRate = pcmrs_pkg::OutputRateDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcmrs_pkg::cfg_t    cfg_i,
  input  logic               q_valid_i,
  input  pcmrs_pkg::pair_t   q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_o,
  output logic signed [15:0] right_o,
  output logic               last_o,
  output pcmrs_pkg::status_t status_o
);

  // accumulator holds a remainder below OutputRate plus one rate step
  localparam int AccW = $clog2(OutputRate + 65536);
  localparam logic [AccW-1:0] RateLim = AccW'(OutputRate);

  pcmrs_pkg::back_state_e        state_q, state_d;
  logic [AccW-1:0]               phase_q, phase_d;
  logic [pcmrs_pkg::CntW-1:0]    count_q, count_d;
  logic [1:0]                    skip_q, skip_d;
  pcmrs_pkg::pair_t              pair_q, pair_d;
  logic                          out_valid_q, out_valid_d;
  logic [15:0]                   out_left_q, out_left_d;
  logic [15:0]                   out_right_q, out_right_d;
  logic                          out_last_q, out_last_d;

  logic [AccW-1:0] acc;
  logic [AccW-1:0] acc_rem;
  logic [AccW-1:0] head_rem;
  logic            more;
  logic            emit_ok;
  logic [31:0]     rem32;

  assign acc      = phase_q + AccW'(cfg_i.rate);
  assign acc_rem  = acc - RateLim;
  assign head_rem = phase_q - RateLim;
  assign more     = (acc < RateLim) && (count_q != pcmrs_pkg::CntW'(pcmrs_pkg::MaxRun - 1));
  assign emit_ok  = !out_valid_q || out_ready_i;
  assign rem32    = 32'(phase_q[15:0]);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    count_d     = count_q;
    skip_d      = skip_q;
    pair_d      = pair_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;

    unique case (state_q)
      pcmrs_pkg::StIdle: begin
        // whole source frames before the next output, saturated
        priority if (rem32 >= 32'(3 * OutputRate)) begin
          skip_d = 2'd3;
        end else if (rem32 >= 32'(2 * OutputRate)) begin
          skip_d = 2'd2;
        end else if (rem32 >= 32'(OutputRate)) begin
          skip_d = 2'd1;
        end else begin
          skip_d = 2'd0;
        end
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          pair_d  = q_data_i;
          count_d = '0;
          state_d = pcmrs_pkg::StRun;
        end
      end
      pcmrs_pkg::StRun: begin
        if (phase_q >= RateLim) begin
          // frame skipped, no output
          phase_d = AccW'(head_rem[15:0]);
          state_d = pcmrs_pkg::StIdle;
        end else if (emit_ok) begin
          out_valid_d = 1'b1;
          out_left_d  = pair_q.left;
          out_right_d = pair_q.right;
          out_last_d  = !more;
          if (more) begin
            phase_d = acc;
            count_d = count_q + 1'b1;
          end else begin
            // end of run; a run cut at its limit drops the rest of the frame
            phase_d = (acc < RateLim) ? '0 : AccW'(acc_rem[15:0]);
            state_d = pcmrs_pkg::StIdle;
          end
        end
      end
      default: state_d = pcmrs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcmrs_pkg::StIdle;
      phase_q     <= '0;
      count_q     <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q      <= pair_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign left_o      = $signed(out_left_q);
  assign right_o     = $signed(out_right_q);
  assign last_o      = out_last_q;

  assign status_o.running  = (state_q == pcmrs_pkg::StRun);
  assign status_o.rem_fits = (state_q == pcmrs_pkg::StRun) || (phase_q[AccW-1:16] == '0);
  assign status_o.count    = count_q;
  assign status_o.skip     = skip_q;

endmodule

// ----- hdl/pcm_to_stereo16_nearest_resampler_core.sv -----
`timescale 1ns / 1ps
// nearest-neighbor resampler: source pcm frames in, 16-bit stereo frames out
// in_i carries one source frame per word (first/second sample raw bits);
// out_o carries output frames, last_of_run marks the final one of a frame
// the apb port sets mono/stereo, 8/16-bit and the source rate; address 12
// reads the whole-frames-to-skip count; write only while the block is idle
// a source frame gives 0 to 6 output words
// a taken input word is written into the queue, popped into the back end
// as it enters its run state, and its first output word is then loaded into
// the output register; the back end takes a new frame only once the last
// run or skip is done, stepping the phase accumulator once per output word
// a 2-word queue sits between the input decode and the back end
// reset: phase remainder 0, queue and output register empty, config back to
// stereo, 16-bit, 44100 Hz
// receiver stall: the output register holds its word, the back end waits,
// the queue fills and then in_i.ready drops
module pcm_to_stereo16_nearest_resampler_core #(
  parameter int OutputRate = pcmrs_pkg::OutputRateDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pcmrs_in_if.sink                     in_i,
  pcmrs_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcmrs_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  `include "pcm_to_stereo16_nearest_resampler_core_defines.svh"

  // configuration registers
  pcmrs_pkg::cfg_t    cfg_q, cfg_d;
  pcmrs_pkg::status_t status;
  logic               cfg_wr;
  logic [1:0]         reg_idx;

  // front to queue to back
  logic             q_full;
  logic             q_push;
  pcmrs_pkg::pair_t q_push_data;
  logic             q_valid;
  logic             q_pop;
  pcmrs_pkg::pair_t q_pop_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        pcmrs_pkg::RegStereo:  cfg_d.stereo  = pwdata[0];
        pcmrs_pkg::RegSixteen: cfg_d.sixteen = pwdata[0];
        pcmrs_pkg::RegRate:    cfg_d.rate    = pwdata[15:0];
        pcmrs_pkg::RegStatus:  cfg_d         = cfg_q;  // read only
        default:               cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stereo  <= pcmrs_pkg::StereoReset;
      cfg_q.sixteen <= pcmrs_pkg::SixteenReset;
      cfg_q.rate    <= pcmrs_pkg::RateReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      pcmrs_pkg::RegStereo:  prdata = 32'(cfg_q.stereo);
      pcmrs_pkg::RegSixteen: prdata = 32'(cfg_q.sixteen);
      pcmrs_pkg::RegRate:    prdata = 32'(cfg_q.rate);
      pcmrs_pkg::RegStatus:  prdata = 32'(status.skip);
      default:               prdata = '0;
    endcase
  end

  // input decode: sample widening and mono copy
  pcmrs_front u_front (
    .cfg_i           (cfg_q),
    .in_valid_i      (in_i.valid),
    .first_sample_i  (in_i.first_sample),
    .second_sample_i (in_i.second_sample),
    .in_ready_o      (in_i.ready),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .push_data_o     (q_push_data)
  );

  // decoded frames waiting for the back end
  pcmrs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_pop_data)
  );

  // phase accumulator and output register
  pcmrs_back #(
    .OutputRate (OutputRate)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .left_o      (out_o.left_sample),
    .right_o     (out_o.right_sample),
    .last_o      (out_o.last_of_run),
    .status_o    (status)
  );

  // between frames the stored remainder fits in 16 bits
  `PCMRS_CHECK(a_rem_fits, status.rem_fits)
  // a run never counts past its limit
  `PCMRS_CHECK(a_run_bound, status.count < pcmrs_pkg::CntW'(pcmrs_pkg::MaxRun))
  // a new output word only comes out of a running back end
  `PCMRS_CHECK_IMPL(a_out_from_run, $rose(out_o.valid), $past(status.running))

endmodule

// ----- bench/pcmrs_resample_check.sv -----
`timescale 1ns / 1ps
module pcmrs_resample_check #(
  parameter int OutputRate = pcmrs_pkg::OutputRateDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pcmrs_in_if                          in_i,
  pcmrs_out_if                         out_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcmrs_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           mismatches_o,
  output int                           pending_o
);
  import pcmrs_pkg::*;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } stereo_word_t;

  stereo_word_t expected_words[$];
  int           mismatch_count;

  // shadow of the format registers, taken from the apb bus
  logic         stereo_cfg;
  logic         sixteen_cfg;
  logic [15:0]  rate_cfg;
  logic [15:0]  phase_rem;

  function automatic logic [15:0] to_pcm16(logic [15:0] raw, logic sixteen);
    // 8-bit unsigned: (s - 128) * 256 is the low byte with its msb flipped
    return sixteen ? raw : {raw[7:0] ^ 8'h80, 8'h00};
  endfunction

  function automatic void resample_frame(logic [15:0] first, logic [15:0] second);
    logic [15:0]  left;
    logic [15:0]  right;
    logic [17:0]  acc;
    int           n;
    stereo_word_t w;
    left  = to_pcm16(first, sixteen_cfg);
    right = stereo_cfg ? to_pcm16(second, sixteen_cfg) : left;
    acc   = {2'b00, phase_rem};
    n     = 0;
    while (acc < 18'(OutputRate) && n < MaxRun) begin
      w.left  = left;
      w.right = right;
      w.last  = (acc + 18'(rate_cfg) >= 18'(OutputRate)) || (n == MaxRun - 1);
      expected_words.push_back(w);
      n++;
      acc += 18'(rate_cfg);
    end
    // run cut short: the rest of this frame is dropped
    if (acc < 18'(OutputRate)) acc = 18'(OutputRate);
    acc -= 18'(OutputRate);
    phase_rem = acc[15:0];
  endfunction

  function automatic void compare_field(string field, logic signed [15:0] want,
                                        logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_word_t w;
    if (!rst_ni) begin
      expected_words.delete();
      mismatch_count = 0;
      stereo_cfg     = StereoReset;
      sixteen_cfg    = SixteenReset;
      rate_cfg       = RateReset;
      phase_rem      = '0;
      mismatches_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PaddrW-1:2])
          RegStereo:  stereo_cfg  = pwdata[0];
          RegSixteen: sixteen_cfg = pwdata[0];
          RegRate:    rate_cfg    = pwdata[15:0];
          default: ;
        endcase
      end
      // outputs first: a word taken now cannot come from a frame taken now
      if (out_i.valid && out_i.ready) begin
        if (expected_words.size() == 0) begin
          $error("output word with none expected: left_sample %0d right_sample %0d",
                 out_i.left_sample, out_i.right_sample);
          mismatch_count++;
        end else begin
          w = expected_words.pop_front();
          compare_field("left_sample", w.left, out_i.left_sample);
          compare_field("right_sample", w.right, out_i.right_sample);
          compare_field("last_of_run", {15'd0, w.last}, {15'd0, out_i.last_of_run});
        end
      end
      if (in_i.valid && in_i.ready) resample_frame(in_i.first_sample, in_i.second_sample);
      mismatches_o <= mismatch_count;
      pending_o    <= expected_words.size();
    end
  end

endmodule

// ----- bench/pcm_to_stereo16_nearest_resampler_core_tb.sv -----
`timescale 1ns / 1ps
module pcm_to_stereo16_nearest_resampler_core_tb;
  import pcmrs_pkg::*;

  // worst case is ~6 words per frame, each behind a long receiver stall,
  // plus long sender gaps; this is several times that
  localparam int CycleLimit    = 600000;
  // cycles to let skipped frames clear the 2-word queue and back end
  localparam int DrainCycles   = 16;
  localparam int RandomPhases  = 12;
  localparam int ItemsPerPhase = 36;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  mismatches;
  int                  pending;
  bit                  burst_mode;

  pcmrs_in_if  in_ch ();
  pcmrs_out_if out_ch ();

  pcm_to_stereo16_nearest_resampler_core #(
    .OutputRate(OutputRateDefault)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pcmrs_resample_check #(
    .OutputRate(OutputRateDefault)
  ) resample_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sender gap: mostly none, some short, a few long; none at all in burst mode
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // raw sample bits, with the all-zero and all-one words now and then
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // source rate: mostly inside 8000..48000, plus the extremes and out-of-range values
  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 19))
      0:       return 16'd8000;
      1:       return 16'd48000;
      2:       return 16'd44100;
      3:       return 16'd0;
      4:       return 16'($urandom_range(1, 7999));
      5:       return 16'($urandom_range(48001, 65535));
      default: return 16'($urandom_range(8000, 48000));
    endcase
  endfunction

  // all tasks below start and end on a falling edge with nothing driven yet there

  // one source frame: optional gap, then hold the word until it is taken
  task automatic send_frame(logic [15:0] first, logic [15:0] second);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         = 1'b1;
    in_ch.first_sample  = first;
    in_ch.second_sample = second;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // stop sending until every expected word is out, then let skipped frames
  // drain, since they give no word to wait for
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // setup cycle, then access cycle; the register takes the value when pready is seen
  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PaddrW'({reg_idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
  endtask

  // format changes only while idle; the phase remainder carries over
  task automatic set_format(bit stereo, bit sixteen, logic [15:0] rate);
    wait_drained();
    apb_write(RegStereo, {31'd0, stereo});
    apb_write(RegSixteen, {31'd0, sixteen});
    apb_write(RegRate, {16'd0, rate});
  endtask

  // receiver: random stalls, now and then a calm stretch with ready held high
  initial begin : receiver
    int hold;
    int calm_left;
    int r;
    out_ch.ready = 1'b0;
    hold         = 0;
    calm_left    = 0;
    forever begin
      @(negedge clk_i);
      if (calm_left > 0) begin
        calm_left--;
        out_ch.ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = $urandom_range(50, 200);
        else if (r < 8) hold = $urandom_range(8, 40);
        else if (r < 35) hold = $urandom_range(1, 3);
      end
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int          i;
    bit          stereo;
    bit          sixteen;
    logic [15:0] rate;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.first_sample  = '0;
    in_ch.second_sample = '0;
    burst_mode          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset format: stereo 16-bit at 44100, one word per frame; sign extremes
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0001, 16'hFFFE);

    // mono 8-bit at the lowest rate: up to six words per frame, high byte
    // and second sample ignored
    set_format(1'b0, 1'b0, 16'd8000);
    send_frame(16'h00FF, 16'h1234);
    send_frame(16'hFF00, 16'hABCD);
    send_frame(16'h0080, 16'hFFFF);
    send_frame(16'hFF7F, 16'h0000);

    // stereo 8-bit at the highest rate: each of these frames gives one word
    set_format(1'b1, 1'b0, 16'd48000);
    send_frame(16'h00FF, 16'hFF00);
    send_frame(16'h0000, 16'h00FF);
    send_frame(16'hAA55, 16'h55AA);
    send_frame(16'h0180, 16'hFE7F);

    // zero rate: every frame hits the run cap and the remainder is dropped
    set_format(1'b0, 1'b1, 16'd0);
    send_frame(16'h8000, 16'h1111);
    send_frame(16'h7FFF, 16'h2222);

    // below the range: run cap again, the remainder dropped each time
    set_format(1'b1, 1'b1, 16'd5000);
    send_frame(16'h1234, 16'hEDCB);
    send_frame(16'hFFFF, 16'h0001);

    // above the range: now and then a frame gives no word
    set_format(1'b1, 1'b1, 16'd65535);
    send_frame(16'h0F0F, 16'hF0F0);
    send_frame(16'h3C3C, 16'hC3C3);
    send_frame(16'h5A5A, 16'hA5A5);
    send_frame(16'h6969, 16'h9696);

    // random formats, random samples
    for (p = 0; p < RandomPhases; p++) begin
      stereo     = 1'($urandom_range(0, 1));
      sixteen    = 1'($urandom_range(0, 1));
      rate       = pick_rate();
      set_format(stereo, sixteen, rate);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (i = 0; i < ItemsPerPhase; i++) begin
        // once, hold off mid-stream until the block has caught up
        if (p == RandomPhases / 2 && i == ItemsPerPhase / 2) wait_drained();
        send_frame(pick_sample(), pick_sample());
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
